// ===== hw/rtl/bounded_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded priority queue
// Implication checks with an asynchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_PRIORITY_QUEUE_ASSERT_SVH
`define BOUNDED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define BPQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bpq check failed");

// next-cycle implication
`define BPQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bpq check failed");

`endif

// ===== hw/rtl/bpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types, operation and status codes for the bounded priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpq_pkg;

	localparam int DEPTH_DEF         = 16;
	localparam int VALUE_BITS_DEF    = 32;
	localparam int PRIORITY_BITS_DEF = 8;

	localparam int FUNC_W   = 2;
	localparam int IVALUE_W = 32;
	localparam int IPRIO_W  = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int OVALUE_W = 32;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [IVALUE_W-1:0] item_value;
		logic [IPRIO_W-1:0]  item_priority;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count;
		logic [OVALUE_W-1:0] oldest_value;
		logic                oldest_valid;
	} rsp_t;

endpackage

// ===== hw/rtl/bounded_priority_queue.sv =====
// ----------------------------------------------------------------------------
// bounded_priority_queue
// Stable priority queue of up to DEPTH entries held in one entry store.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req (req_valid/req_ready); each yields exactly one
//   response on rsp (rsp_valid/rsp_ready). func selects insert, remove of the
//   oldest highest-priority entry, or query.
//   Insert and query: the sequencer registers the result in its done state,
//   then the output register takes it; no new request is taken until then.
//   Remove with N stored entries: a scan reads all N entries through the
//   store's read port, one per cycle, then the younger entries are moved down
//   one per cycle, paced by the store's single read port.
//   A response waits in an output register; the next request is taken while
//   it waits, and the sequencer holds its finished result until that
//   register frees. A stalled receiver thus stalls at most one request.
//   Reset empties the queue at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bounded_priority_queue_assert.svh"

module bounded_priority_queue #(
	parameter int DEPTH         = bpq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS    = bpq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = bpq_pkg::PRIORITY_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bpq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output bpq_pkg::rsp_t rsp
);

	logic          res_valid;
	logic          res_ready;
	bpq_pkg::rsp_t res;
	logic          rsp_valid_q;
	bpq_pkg::rsp_t rsp_q;

	bpq_engine #(
		.DEPTH         (DEPTH),
		.VALUE_BITS    (VALUE_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BPQ_ASSERT_NXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)
	`BPQ_ASSERT_IMP(a_no_req_while_res, clk, arst_n, res_valid, !req_ready)
	`BPQ_ASSERT_IMP(a_full_not_empty, clk, arst_n, rsp_valid && rsp.status == bpq_pkg::ST_FULL, rsp.oldest_valid)
	`BPQ_ASSERT_IMP(a_empty_zero, clk, arst_n, rsp_valid && rsp.status == bpq_pkg::ST_EMPTY, !rsp.oldest_valid && rsp.oldest_value == '0)

endmodule

// ===== hw/rtl/bpq_mem.sv =====
// ----------------------------------------------------------------------------
// bpq_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpq_mem #(
	parameter int DEPTH = bpq_pkg::DEPTH_DEF,
	parameter int WIDTH = bpq_pkg::VALUE_BITS_DEF + bpq_pkg::PRIORITY_BITS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bpq_engine.sv =====
// ----------------------------------------------------------------------------
// bpq_engine
// Request sequencer: append on insert, scan-then-compact on remove, report on query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpq_engine #(
	parameter int DEPTH         = bpq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS    = bpq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = bpq_pkg::PRIORITY_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  bpq_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output bpq_pkg::rsp_t res
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int MW    = VALUE_BITS + PRIORITY_BITS;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0]                 state_q;
	logic [CNT_W-1:0]           count_q;
	logic [VALUE_BITS-1:0]      oldest_q;
	logic [bpq_pkg::STATUS_W-1:0] status_q;
	logic [CNT_W-1:0]           ptr_q;
	logic                       vld_s1;
	logic [AW-1:0]              idx_s1;
	logic [PRIORITY_BITS-1:0]   best_prio_q;
	logic [AW-1:0]              best_idx_q;

	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [MW-1:0]              wr_data;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	logic [MW-1:0]              rd_data;

	logic                       full;
	logic                       empty;
	logic                       more;
	logic [PRIORITY_BITS-1:0]   rd_prio;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign more    = (ptr_q < count_q);
	assign rd_prio = rd_data[MW-1:VALUE_BITS];

	bpq_mem #(
		.DEPTH (DEPTH),
		.WIDTH (MW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// memory port control; each phase owns the port, so no same-entry overlap
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = {PRIORITY_BITS'(req.item_priority), VALUE_BITS'(req.item_value)};
		rd_en   = 1'b0;
		rd_addr = ptr_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && req.func == bpq_pkg::FUNC_INSERT && !full) begin
					wr_en = 1'b1;
				end
				if (req_valid && req.func == bpq_pkg::FUNC_REMOVE && !empty) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			S_SCAN: begin
				rd_en = more;
			end
			S_SHIFT: begin
				rd_en = more;
				if (vld_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1;
					wr_data = rd_data;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			oldest_q    <= '0;
			status_q    <= bpq_pkg::ST_OK;
			ptr_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			best_prio_q <= '0;
			best_idx_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						status_q <= bpq_pkg::ST_OK;
						state_q  <= S_DONE;
						unique case (req.func)
							bpq_pkg::FUNC_INSERT: begin
								if (full) begin
									status_q <= bpq_pkg::ST_FULL;
								end else begin
									if (empty) begin
										oldest_q <= VALUE_BITS'(req.item_value);
									end
									count_q <= count_q + CNT_W'(1);
								end
							end
							bpq_pkg::FUNC_REMOVE: begin
								if (empty) begin
									status_q <= bpq_pkg::ST_EMPTY;
								end else begin
									ptr_q   <= CNT_W'(1);
									idx_s1  <= '0;
									vld_s1  <= 1'b1;
									state_q <= S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					// first maximum wins: strict compare keeps the oldest on a tie
					if (vld_s1 && (idx_s1 == '0 || rd_prio > best_prio_q)) begin
						best_prio_q <= rd_prio;
						best_idx_q  <= idx_s1;
					end
					if (vld_s1) begin
						vld_s1 <= more;
						if (more) begin
							idx_s1 <= ptr_q[AW-1:0];
							ptr_q  <= ptr_q + CNT_W'(1);
						end
					end else begin
						ptr_q   <= CNT_W'(best_idx_q) + CNT_W'(1);
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					// read entry i+1 while entry i-1 is written back
					if (vld_s1 && idx_s1 == '0) begin
						oldest_q <= rd_data[VALUE_BITS-1:0];
					end
					vld_s1 <= more;
					if (more) begin
						idx_s1 <= AW'(ptr_q - CNT_W'(1));
						ptr_q  <= ptr_q + CNT_W'(1);
					end else if (!vld_s1) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready        = (state_q == S_IDLE);
	assign res_valid        = (state_q == S_DONE);
	assign res.status       = status_q;
	assign res.entry_count  = bpq_pkg::COUNT_W'(count_q);
	assign res.oldest_value = empty ? '0 : bpq_pkg::OVALUE_W'(oldest_q);
	assign res.oldest_valid = !empty;

endmodule
